[rtl/aws_pkg.sv]
// Shared types, constants and CORDIC helpers of the stereo arctangent waveshaper.
// Used by every module in rtl; depends on nothing.
`default_nettype none
package aws_pkg;

   localparam int CORDIC_STEPS = 31;
   localparam int CORDIC_BITS  = 48;
   localparam int ANGLE_BITS   = 32;
   localparam int NORM_BITS    = 31;
   localparam int GAIN_BITS    = 13;
   localparam int UNIT_SHIFT   = 40;
   localparam int GAIN_MIN     = 26;
   localparam int GAIN_MAX     = 5120;

   localparam logic [1:0] REG_GAIN_POS   = 2'd0;
   localparam logic [1:0] REG_GAIN_NEG   = 2'd1;
   localparam logic [1:0] REG_STAGES     = 2'd2;
   localparam logic [1:0] REG_INVERT_ALT = 2'd3;

   typedef struct packed {
      logic signed [CORDIC_BITS-1:0] x;
      logic signed [CORDIC_BITS-1:0] y;
      logic signed [ANGLE_BITS-1:0]  z;
   } cordic_vec_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0] gain_pos;
      logic [GAIN_BITS-1:0] gain_neg;
      logic [NORM_BITS-1:0] norm_pos;
      logic [NORM_BITS-1:0] norm_neg;
      logic                 active;
      logic                 invert;
   } stage_cfg_type;

   typedef enum logic [2:0] {
      NORM_LOAD_POS,
      NORM_RUN_POS,
      NORM_LOAD_NEG,
      NORM_RUN_NEG,
      NORM_DONE
   } norm_state_type;

   // atan(2^-i) in Q30
   function automatic logic [ANGLE_BITS-1:0] angle_q30(input logic [4:0] i);
      logic [ANGLE_BITS-1:0] a;
      case (i)
         5'd0:  a = 32'h3243F6A8;
         5'd1:  a = 32'h1DAC6705;
         5'd2:  a = 32'h0FADBAFC;
         5'd3:  a = 32'h07F56EA6;
         5'd4:  a = 32'h03FEAB76;
         5'd5:  a = 32'h01FFD55B;
         5'd6:  a = 32'h00FFFAAA;
         5'd7:  a = 32'h007FFF55;
         5'd8:  a = 32'h003FFFEA;
         5'd9:  a = 32'h001FFFFD;
         5'd10: a = 32'h000FFFFF;
         5'd11: a = 32'h0007FFFF;
         5'd12: a = 32'h0003FFFF;
         5'd13: a = 32'h0001FFFF;
         5'd14: a = 32'h0000FFFF;
         5'd15: a = 32'h00007FFF;
         5'd16: a = 32'h00003FFF;
         5'd17: a = 32'h00001FFF;
         5'd18: a = 32'h00000FFF;
         5'd19: a = 32'h000007FF;
         5'd20: a = 32'h000003FF;
         5'd21: a = 32'h000001FF;
         5'd22: a = 32'h000000FF;
         5'd23: a = 32'h0000007F;
         5'd24: a = 32'h0000003F;
         5'd25: a = 32'h0000001F;
         5'd26: a = 32'h0000000F;
         5'd27: a = 32'h00000008;
         5'd28: a = 32'h00000004;
         5'd29: a = 32'h00000002;
         5'd30: a = 32'h00000001;
         default: a = '0;
      endcase
      return a;
   endfunction

   // one vectoring micro-rotation, arithmetic shifts round toward minus infinity
   function automatic cordic_vec_type cordic_iter(input cordic_vec_type v,
                                                  input logic [4:0] i);
      cordic_vec_type r;
      logic signed [CORDIC_BITS-1:0] dx;
      logic signed [CORDIC_BITS-1:0] dy;
      logic signed [ANGLE_BITS-1:0]  a;
      dx = v.y >>> i;
      dy = v.x >>> i;
      a  = signed'(angle_q30(i));
      if (!v.y[CORDIC_BITS-1]) begin
         r.x = v.x + dx;
         r.y = v.y - dy;
         r.z = v.z + a;
      end else begin
         r.x = v.x - dx;
         r.y = v.y + dy;
         r.z = v.z - a;
      end
      return r;
   endfunction

   function automatic cordic_vec_type cordic_start(input logic [CORDIC_BITS-1:0] y0);
      cordic_vec_type r;
      r.x = signed'(CORDIC_BITS'(1) << UNIT_SHIFT);
      r.y = signed'(y0);
      r.z = '0;
      return r;
   endfunction

   // clamp a final angle to a non-negative normalisation value
   function automatic logic [NORM_BITS-1:0] angle_clamp(input logic signed [ANGLE_BITS-1:0] z);
      return z[ANGLE_BITS-1] ? '0 : z[NORM_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

[rtl/aws_cordic_cell.sv]
// One registered CORDIC vectoring iteration with a side tag carried alongside.
// Depends on aws_pkg.
`default_nettype none
module aws_cordic_cell #(
   parameter int ITER     = 0,
   parameter int TAG_BITS = 25
) (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire aws_pkg::cordic_vec_type vec_in,
   input  wire logic [TAG_BITS-1:0]    tag_in,
   output      aws_pkg::cordic_vec_type vec_out,
   output      logic [TAG_BITS-1:0]    tag_out
);

   aws_pkg::cordic_vec_type vec_ff, vec_in_nxt;
   logic [TAG_BITS-1:0]     tag_ff;

   assign vec_in_nxt = aws_pkg::cordic_iter(vec_in, 5'(ITER));

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in_nxt;
         tag_ff <= tag_in;
      end
   end

   assign vec_out = vec_ff;
   assign tag_out = tag_ff;

endmodule
`default_nettype wire

[rtl/aws_div_cell.sv]
// One registered restoring-division step: resolves quotient bit SHIFT.
// Depends on aws_pkg for the normalisation width.
`default_nettype none
module aws_div_cell #(
   parameter int SAMPLE_BITS = 24,
   parameter int SHIFT       = 0,
   parameter int REM_BITS    = SAMPLE_BITS + 31,
   parameter int TAG_BITS    = SAMPLE_BITS + 1
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [aws_pkg::NORM_BITS-1:0] norm_pos,
   input  wire logic [aws_pkg::NORM_BITS-1:0] norm_neg,
   input  wire logic [REM_BITS-1:0]           rem_in,
   input  wire logic [SAMPLE_BITS-2:0]        quo_in,
   input  wire logic [TAG_BITS-1:0]           tag_in,
   output      logic [REM_BITS-1:0]           rem_out,
   output      logic [SAMPLE_BITS-2:0]        quo_out,
   output      logic [TAG_BITS-1:0]           tag_out
);

   logic [aws_pkg::NORM_BITS-1:0] divisor;
   logic [REM_BITS-1:0]           dsh;
   logic                          fits;
   logic [REM_BITS-1:0]           rem_ff, rem_in_nxt;
   logic [SAMPLE_BITS-2:0]        quo_ff, quo_in_nxt;
   logic [TAG_BITS-1:0]           tag_ff;

   always_comb begin
      divisor = tag_in[SAMPLE_BITS-1] ? norm_neg : norm_pos;
      dsh     = {{(REM_BITS-aws_pkg::NORM_BITS){1'b0}}, divisor} << SHIFT;
      fits    = (rem_in >= dsh);
      rem_in_nxt = fits ? (rem_in - dsh) : rem_in;
      quo_in_nxt = quo_in;
      quo_in_nxt[SHIFT] = fits;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in_nxt;
         quo_ff <= quo_in_nxt;
         tag_ff <= tag_in;
      end
   end

   assign rem_out = rem_ff;
   assign quo_out = quo_ff;
   assign tag_out = tag_ff;

endmodule
`default_nettype wire

[rtl/aws_stage.sv]
// One shaping stage for one channel: magnitude and gain, CORDIC row, division row, sign.
// Depends on aws_pkg, aws_cordic_cell and aws_div_cell.
`default_nettype none
module aws_stage #(
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire aws_pkg::stage_cfg_type cfg,
   input  wire logic [SAMPLE_BITS-1:0] x_in,
   output      logic [SAMPLE_BITS-1:0] y_out
);

   localparam int F   = SAMPLE_BITS - 1;
   localparam int TW  = SAMPLE_BITS + 1;
   localparam int NW  = F + 32;
   localparam int CS  = aws_pkg::CORDIC_STEPS;
   localparam int CW  = aws_pkg::CORDIC_BITS;
   localparam int GB  = aws_pkg::GAIN_BITS;

   // front: magnitude times gain, lifted to Q40
   logic                   neg;
   logic [SAMPLE_BITS-1:0] mag;
   logic [GB-1:0]          gain;
   logic [SAMPLE_BITS+GB-1:0] prod;
   logic [CW-1:0]          t;

   aws_pkg::cordic_vec_type cvec [CS+1];
   logic [TW-1:0]           ctag [CS+1];

   always_comb begin
      neg  = x_in[SAMPLE_BITS-1];
      mag  = neg ? (~x_in + 1'b1) : x_in;
      gain = neg ? cfg.gain_neg : cfg.gain_pos;
      prod = mag * gain;
      t    = {{(CW-SAMPLE_BITS-GB){1'b0}}, prod} << (32 - F);
   end

   aws_pkg::cordic_vec_type front_vec_ff;
   logic [TW-1:0]           front_tag_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         front_vec_ff <= aws_pkg::cordic_start(t);
         front_tag_ff <= {(mag == '0), x_in};
      end
   end

   assign cvec[0] = front_vec_ff;
   assign ctag[0] = front_tag_ff;

   for (genvar i = 0; i < CS; i++) begin : g_cordic
      aws_cordic_cell #(.ITER(i), .TAG_BITS(TW)) u_cell (
         .clock   (clock),
         .en      (en),
         .vec_in  (cvec[i]),
         .tag_in  (ctag[i]),
         .vec_out (cvec[i+1]),
         .tag_out (ctag[i+1])
      );
   end

   // normalise: numerator, rounding half divisor, saturation check
   logic [SAMPLE_BITS-1:0]        cx;
   logic [aws_pkg::NORM_BITS-1:0] zc;
   logic [aws_pkg::NORM_BITS-1:0] dsel;
   logic [NW-1:0]                 numer;
   logic                          sat;
   logic [NW-1:0]                 num_ff;
   logic [TW-1:0]                 num_tag_ff;

   always_comb begin
      cx    = ctag[CS][SAMPLE_BITS-1:0];
      zc    = ctag[CS][SAMPLE_BITS] ? '0 : aws_pkg::angle_clamp(cvec[CS].z);
      dsel  = cx[SAMPLE_BITS-1] ? cfg.norm_neg : cfg.norm_pos;
      numer = {1'b0, zc, {F{1'b0}}} + {{(NW-aws_pkg::NORM_BITS+1){1'b0}}, dsel[30:1]};
      sat   = (numer[NW-1:F] >= {1'b0, dsel});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff     <= numer;
         num_tag_ff <= {sat, cx};
      end
   end

   logic [NW-1:0] drem [F+1];
   logic [F-1:0]  dquo [F+1];
   logic [TW-1:0] dtag [F+1];

   assign drem[0] = num_ff;
   assign dquo[0] = '0;
   assign dtag[0] = num_tag_ff;

   for (genvar k = 0; k < F; k++) begin : g_div
      aws_div_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .SHIFT       (F - 1 - k),
         .REM_BITS    (NW),
         .TAG_BITS    (TW)
      ) u_cell (
         .clock    (clock),
         .en       (en),
         .norm_pos (cfg.norm_pos),
         .norm_neg (cfg.norm_neg),
         .rem_in   (drem[k]),
         .quo_in   (dquo[k]),
         .tag_in   (dtag[k]),
         .rem_out  (drem[k+1]),
         .quo_out  (dquo[k+1]),
         .tag_out  (dtag[k+1])
      );
   end

   // tail: saturate, restore sign, optional inversion, bypass when inactive
   logic [SAMPLE_BITS-1:0] tx;
   logic [F-1:0]           q;
   logic [SAMPLE_BITS-1:0] mag_out;
   logic [SAMPLE_BITS-1:0] shaped;
   logic [SAMPLE_BITS-1:0] y_ff;

   always_comb begin
      tx      = dtag[F][SAMPLE_BITS-1:0];
      q       = dtag[F][SAMPLE_BITS] ? '1 : dquo[F];
      mag_out = {1'b0, q};
      shaped  = (tx[SAMPLE_BITS-1] ^ cfg.invert) ? (~mag_out + 1'b1) : mag_out;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= cfg.active ? shaped : tx;
      end
   end

   assign y_out = y_ff;

endmodule
`default_nettype wire

[rtl/aws_norm.sv]
// Sequential CORDIC that derives atan(k) in Q30 for both gains after reset or a gain write.
// Depends on aws_pkg.
`default_nettype none
module aws_norm (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          restart,
   input  wire logic [aws_pkg::GAIN_BITS-1:0] gain_pos,
   input  wire logic [aws_pkg::GAIN_BITS-1:0] gain_neg,
   output      logic [aws_pkg::NORM_BITS-1:0] norm_pos,
   output      logic [aws_pkg::NORM_BITS-1:0] norm_neg,
   output      logic                          busy
);

   localparam logic [4:0] LAST_ITER = 5'(aws_pkg::CORDIC_STEPS - 1);

   aws_pkg::norm_state_type       state_ff, state_in;
   aws_pkg::cordic_vec_type       vec_ff, vec_in;
   aws_pkg::cordic_vec_type       step;
   logic [4:0]                    iter_ff, iter_in;
   logic [aws_pkg::NORM_BITS-1:0] pos_ff, pos_in;
   logic [aws_pkg::NORM_BITS-1:0] neg_ff, neg_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aws_pkg::NORM_LOAD_POS;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
      pos_ff <= pos_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      state_in = state_ff;
      vec_in   = vec_ff;
      iter_in  = iter_ff;
      pos_in   = pos_ff;
      neg_in   = neg_ff;
      step     = aws_pkg::cordic_iter(vec_ff, iter_ff);
      unique case (state_ff)
         aws_pkg::NORM_LOAD_POS: begin
            vec_in   = aws_pkg::cordic_start({3'b000, gain_pos, 32'h0});
            iter_in  = '0;
            state_in = aws_pkg::NORM_RUN_POS;
         end
         aws_pkg::NORM_RUN_POS: begin
            vec_in  = step;
            iter_in = iter_ff + 5'd1;
            if (iter_ff == LAST_ITER) begin
               pos_in   = aws_pkg::angle_clamp(step.z);
               state_in = aws_pkg::NORM_LOAD_NEG;
            end
         end
         aws_pkg::NORM_LOAD_NEG: begin
            vec_in   = aws_pkg::cordic_start({3'b000, gain_neg, 32'h0});
            iter_in  = '0;
            state_in = aws_pkg::NORM_RUN_NEG;
         end
         aws_pkg::NORM_RUN_NEG: begin
            vec_in  = step;
            iter_in = iter_ff + 5'd1;
            if (iter_ff == LAST_ITER) begin
               neg_in   = aws_pkg::angle_clamp(step.z);
               state_in = aws_pkg::NORM_DONE;
            end
         end
         aws_pkg::NORM_DONE: begin
            state_in = aws_pkg::NORM_DONE;
         end
         default: begin
            state_in = aws_pkg::NORM_LOAD_POS;
         end
      endcase
      if (restart) begin
         state_in = aws_pkg::NORM_LOAD_POS;
      end
   end

   assign norm_pos = pos_ff;
   assign norm_neg = neg_ff;
   assign busy     = (state_ff != aws_pkg::NORM_DONE);

endmodule
`default_nettype wire

[rtl/arctan_waveshaper_stereo.sv]
// Top level of the stereo multistage asymmetric arctangent waveshaper.
// Depends on aws_pkg, aws_stage (and its cells) and aws_norm.
//
//   port group | direction | words carried
//   req_       | in        | left_sample, right_sample (signed Q1.F)
//   rsp_       | out       | left_shaped, right_shaped (signed Q1.F, saturated)
//   csr_       | in        | write enable, register index, 13-bit data
//
// One word enters per cycle unless req_stall is high. Every stage is built regardless
// of stage_count; idle ones pass the word through.
// A stage is one gain cell, 31 CORDIC cells, one normalise cell, SAMPLE_BITS-1
// division cells and one sign cell, each one register deep.
// After reset and after any gain write, req_stall stays high while
// atan(gain) is derived serially for both gains.
// Bubbles keep moving while a result waits on rsp_stall; the row halts only when its
// last cell holds a word and the output register is still occupied.
`default_nettype none
module arctan_waveshaper_stereo #(
   parameter int SAMPLE_BITS = 24,
   parameter int MAX_STAGES  = 10
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  wire logic signed [SAMPLE_BITS-1:0] req_right_sample,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic signed [SAMPLE_BITS-1:0] rsp_left_shaped,
   output      logic signed [SAMPLE_BITS-1:0] rsp_right_shaped,
   input  wire logic                          csr_write_enable,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [aws_pkg::GAIN_BITS-1:0] csr_data
);

   localparam int STAGE_LAT = SAMPLE_BITS + 33;
   localparam int LAT       = MAX_STAGES * STAGE_LAT;
   localparam int GB        = aws_pkg::GAIN_BITS;

   // configuration registers
   logic [GB-1:0] gain_pos_ff;
   logic [GB-1:0] gain_neg_ff;
   logic [3:0]    stage_count_ff;
   logic          invert_ff;
   logic          gain_ok;
   logic          count_ok;
   logic          restart;

   assign gain_ok  = (int'(csr_data) >= aws_pkg::GAIN_MIN) &&
                     (int'(csr_data) <= aws_pkg::GAIN_MAX);
   assign count_ok = (csr_data[3:0] != 4'd0) && (int'(csr_data[3:0]) <= MAX_STAGES);
   assign restart  = csr_write_enable &&
                     ((csr_index == aws_pkg::REG_GAIN_POS) ||
                      (csr_index == aws_pkg::REG_GAIN_NEG));

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_pos_ff    <= GB'(256);
         gain_neg_ff    <= GB'(256);
         stage_count_ff <= 4'd1;
         invert_ff      <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            aws_pkg::REG_GAIN_POS: begin
               if (gain_ok) gain_pos_ff <= csr_data;
            end
            aws_pkg::REG_GAIN_NEG: begin
               if (gain_ok) gain_neg_ff <= csr_data;
            end
            aws_pkg::REG_STAGES: begin
               if (count_ok) stage_count_ff <= csr_data[3:0];
            end
            aws_pkg::REG_INVERT_ALT: begin
               invert_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // normalisation values, derived serially from the gains
   logic [aws_pkg::NORM_BITS-1:0] norm_pos;
   logic [aws_pkg::NORM_BITS-1:0] norm_neg;
   logic                          norm_busy;

   aws_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .restart  (restart),
      .gain_pos (gain_pos_ff),
      .gain_neg (gain_neg_ff),
      .norm_pos (norm_pos),
      .norm_neg (norm_neg),
      .busy     (norm_busy)
   );

   // flow control: advance the row unless its last word cannot leave
   logic [LAT-1:0]         valid_ff;
   logic                   out_free;
   logic                   en;
   logic                   accept;
   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_left_ff;
   logic [SAMPLE_BITS-1:0] rsp_right_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign en        = !valid_ff[LAT-1] || out_free;
   assign req_stall = norm_busy || !en;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAT-2:0], accept};
      end
   end

   // stage row, one per channel
   aws_pkg::stage_cfg_type cfg [MAX_STAGES];
   logic [SAMPLE_BITS-1:0] left_x  [MAX_STAGES+1];
   logic [SAMPLE_BITS-1:0] right_x [MAX_STAGES+1];

   assign left_x[0]  = req_left_sample;
   assign right_x[0] = req_right_sample;

   for (genvar s = 0; s < MAX_STAGES; s++) begin : g_stage
      // even-numbered stages take the inversion when it is switched on
      assign cfg[s] = '{
         gain_pos : gain_pos_ff,
         gain_neg : gain_neg_ff,
         norm_pos : norm_pos,
         norm_neg : norm_neg,
         active   : (int'(stage_count_ff) > s),
         invert   : invert_ff && ((s % 2) == 0)
      };

      aws_stage #(.SAMPLE_BITS(SAMPLE_BITS)) u_left (
         .clock (clock),
         .en    (en),
         .cfg   (cfg[s]),
         .x_in  (left_x[s]),
         .y_out (left_x[s+1])
      );

      aws_stage #(.SAMPLE_BITS(SAMPLE_BITS)) u_right (
         .clock (clock),
         .en    (en),
         .cfg   (cfg[s]),
         .x_in  (right_x[s]),
         .y_out (right_x[s+1])
      );
   end

   // output register: hold while stalled, load the last word otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= valid_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_left_ff  <= left_x[MAX_STAGES];
         rsp_right_ff <= right_x[MAX_STAGES];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_shaped  = signed'(rsp_left_ff);
   assign rsp_right_shaped = signed'(rsp_right_ff);

endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the stereo arctangent waveshaper.
// Depends on aws_pkg and arctan_waveshaper_stereo; predicts each shaped pair
// and compares it with what the block returns.
`timescale 1ns / 1ps
module testbench;

   localparam int SB       = 24;
   localparam int FB       = SB - 1;
   localparam int NSTAGES  = 10;
   localparam int LATENCY  = NSTAGES * (SB + 33) + 1;
   localparam int LIMIT    = 4000000;
   localparam int GBITS    = aws_pkg::GAIN_BITS;
   localparam logic signed [SB-1:0] FULL_POS = 24'sh7FFFFF;
   localparam logic signed [SB-1:0] FULL_NEG = -24'sh800000;

   typedef struct packed {
      logic signed [SB-1:0] left;
      logic signed [SB-1:0] right;
   } pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SB-1:0] req_left_sample = '0;
   logic signed [SB-1:0] req_right_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SB-1:0] rsp_left_shaped;
   logic signed [SB-1:0] rsp_right_shaped;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = aws_pkg::REG_GAIN_POS;
   logic [GBITS-1:0] csr_data = '0;

   // shaping settings as the block should hold them
   logic [12:0] gain_pos_now, gain_neg_now;
   logic [3:0]  stages_now;
   logic        invert_now;

   pair_type pending_pairs[$];
   pair_type shaped_expected[$];
   int mismatches = 0;
   int cycle_count = 0;
   int send_wait = 0;
   int take_wait = 0;

   arctan_waveshaper_stereo i_dut (.*);

   always #1 clock = ~clock;

   // atan(y0 / 2^40) in Q30 by vectoring CORDIC, floor shifts
   function automatic longint atan_q30(longint y0);
      longint x, y, z, dx, dy, a;
      x = longint'(1) << 40;
      y = y0;
      z = 0;
      if (y0 == 0) return 0;
      for (int i = 0; i < 31; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         a  = longint'(aws_pkg::angle_q30(5'(i)));
         if (y >= 0) begin
            x += dx; y -= dy; z += a;
         end else begin
            x -= dx; y += dy; z -= a;
         end
      end
      return (z < 0) ? 0 : z;
   endfunction

   function automatic logic signed [SB-1:0] shape_sample(logic signed [SB-1:0] s);
      longint v, m, k, z, d, q, lim;
      bit neg;
      lim = (longint'(1) << FB) - 1;
      v = s;
      for (int i = 0; i < stages_now; i++) begin
         neg = v < 0;
         m = neg ? -v : v;
         k = neg ? gain_neg_now : gain_pos_now;
         z = atan_q30((m * k) << (32 - FB));
         d = atan_q30(k << 32);
         q = (d == 0) ? 0 : ((z << FB) + d / 2) / d;
         if (q > lim) q = lim;
         v = neg ? -q : q;
         if (invert_now && (i % 2 == 0)) v = -v;
      end
      return v[SB-1:0];
   endfunction

   // mirror the register write rules, drive one write
   task automatic write_reg(logic [1:0] idx, logic [GBITS-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         aws_pkg::REG_GAIN_POS:
            if (val >= aws_pkg::GAIN_MIN && val <= aws_pkg::GAIN_MAX) gain_pos_now = val;
         aws_pkg::REG_GAIN_NEG:
            if (val >= aws_pkg::GAIN_MIN && val <= aws_pkg::GAIN_MAX) gain_neg_now = val;
         aws_pkg::REG_STAGES:
            if (val[3:0] >= 1 && val[3:0] <= NSTAGES) stages_now = val[3:0];
         aws_pkg::REG_INVERT_ALT: invert_now = val[0];
         default: ;
      endcase
   endtask

   // hold until every shaped word is back and the pipe has drained
   task automatic drain();
      wait (pending_pairs.size() == 0 && shaped_expected.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic signed [SB-1:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return FULL_POS;
         1: return FULL_NEG;
         2: return SB'(int'($urandom_range(0, 64)) - 32);
         default: return SB'($urandom);
      endcase
   endfunction

   task automatic queue_pair(logic signed [SB-1:0] l, logic signed [SB-1:0] r);
      pending_pairs.push_back('{left: l, right: r});
   endtask

   // driver: advance to the next pair after its word is taken
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            shaped_expected.push_back('{left: shape_sample(req_left_sample),
                                        right: shape_sample(req_right_sample)});
            void'(pending_pairs.pop_front());
            req_valid <= 1'b0;
            send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         end else if (!req_valid) begin
            if (send_wait > 0) begin
               send_wait <= send_wait - 1;
            end else if (pending_pairs.size() > 0) begin
               req_valid <= 1'b1;
               req_left_sample <= pending_pairs[0].left;
               req_right_sample <= pending_pairs[0].right;
            end
         end
      end
   end

   // monitor: compare each shaped word with the oldest prediction
   always @(posedge clock) begin
      pair_type exp_pair;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (shaped_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: L=%0d R=%0d", rsp_left_shaped, rsp_right_shaped);
            end else begin
               exp_pair = shaped_expected.pop_front();
               if (exp_pair.left !== rsp_left_shaped || exp_pair.right !== rsp_right_shaped) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                              exp_pair.left, exp_pair.right,
                              rsp_left_shaped, rsp_right_shaped);
               end
            end
         end
         if (take_wait > 0) begin
            take_wait <= take_wait - 1;
            rsp_stall <= 1'b1;
         end else if (($urandom_range(0, 3) != 0) && rsp_stall == 1'b0 && rsp_valid) begin
            take_wait <= $urandom_range(0, 19);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      gain_pos_now = 256;
      gain_neg_now = 256;
      stages_now = 1;
      invert_now = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes at reset settings
      queue_pair(FULL_POS, FULL_NEG);
      queue_pair(24'sd0, -24'sd1);
      queue_pair(24'sd1, 24'sh555555);
      queue_pair(-24'sh2AAAAB, 24'sh400000);
      drain();

      // out-of-range writes must be ignored; then the gain extremes
      write_reg(aws_pkg::REG_GAIN_POS, 13'd25);
      write_reg(aws_pkg::REG_GAIN_NEG, 13'd5121);
      write_reg(aws_pkg::REG_STAGES, 13'd0);
      write_reg(aws_pkg::REG_STAGES, 13'd11);
      write_reg(aws_pkg::REG_GAIN_POS, 13'h1FFF);
      queue_pair(FULL_POS, FULL_NEG);
      queue_pair(24'sh100000, -24'sh100000);
      drain();
      write_reg(aws_pkg::REG_GAIN_POS, GBITS'(aws_pkg::GAIN_MIN));
      write_reg(aws_pkg::REG_GAIN_NEG, GBITS'(aws_pkg::GAIN_MAX));
      write_reg(aws_pkg::REG_STAGES, 13'd10);
      write_reg(aws_pkg::REG_INVERT_ALT, 13'd1);
      queue_pair(FULL_POS, FULL_NEG);
      queue_pair(24'sh000100, -24'sh000100);
      queue_pair(24'sd0, 24'sd1);
      drain();
      write_reg(aws_pkg::REG_GAIN_POS, GBITS'(aws_pkg::GAIN_MAX));
      write_reg(aws_pkg::REG_GAIN_NEG, GBITS'(aws_pkg::GAIN_MIN));
      write_reg(aws_pkg::REG_INVERT_ALT, 13'd0);
      queue_pair(FULL_POS, FULL_NEG);
      queue_pair(-24'sd1, 24'sd1);
      drain();

      // random phases across settings, mostly few stages
      for (int ph = 0; ph < 14; ph++) begin
         write_reg(aws_pkg::REG_GAIN_POS, (ph % 5 == 0) ? GBITS'(aws_pkg::GAIN_MAX) :
                   GBITS'($urandom_range(aws_pkg::GAIN_MIN, aws_pkg::GAIN_MAX)));
         write_reg(aws_pkg::REG_GAIN_NEG, (ph % 5 == 1) ? GBITS'(aws_pkg::GAIN_MIN) :
                   GBITS'($urandom_range(aws_pkg::GAIN_MIN, aws_pkg::GAIN_MAX)));
         write_reg(aws_pkg::REG_STAGES, (ph % 4 == 0) ? GBITS'(NSTAGES) :
                   GBITS'($urandom_range(1, 4)));
         write_reg(aws_pkg::REG_INVERT_ALT, GBITS'($urandom_range(0, 1)));
         if (ph % 6 == 5) write_reg(2'($urandom_range(0, 3)), GBITS'($urandom));
         for (int n = 0; n < 102; n++) queue_pair(rand_sample(), rand_sample());
         drain();
      end
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
